[rtl/tlfs_pkg.sv]
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types and constants of the two-level feedback scheduler.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    localparam int IO_KINDS = 3;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    localparam logic [1:0] REG_DISK_LAT    = 2'd0;
    localparam logic [1:0] REG_TAPE_LAT    = 2'd1;
    localparam logic [1:0] REG_PRINTER_LAT = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [3:0] {
        EV_ARRIVED   = 4'd0,
        EV_RAN_HIGH  = 4'd1,
        EV_RAN_LOW   = 4'd2,
        EV_IO_HIGH   = 4'd3,
        EV_IO_LOW    = 4'd4,
        EV_DONE      = 4'd5,
        EV_IO_RET    = 4'd6,
        EV_TICK_END  = 4'd7,
        EV_LOADED    = 4'd8,
        EV_REFUSED   = 4'd9
    } t_event;

    typedef enum logic [1:0] {
        IO_DISK    = 2'd0,
        IO_TAPE    = 2'd1,
        IO_PRINTER = 2'd2
    } t_io_kind;

    typedef struct packed {
        logic [7:0]                  id;
        logic [15:0]                 arr;
        logic [15:0]                 svc;
        logic [IO_KINDS-1:0][16:0]   pts;
        logic [15:0]                 exec;
        logic [15:0]                 ret;
        logic [1:0]                  kind;
    } t_rec;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK_START,
        OP_ARR_CHK,
        OP_DSP_SEL,
        OP_DSP_EXE,
        OP_DSP_DONE,
        OP_IO_INIT,
        OP_IO_POP,
        OP_IO_CHK,
        OP_TICK_END
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARR_WAIT,
        ST_ARR_CHK,
        ST_DSP_WAIT,
        ST_DSP_SEL,
        ST_DSP_RD,
        ST_DSP_EXE,
        ST_DSP_DONE,
        ST_IO_INIT,
        ST_IO_POP,
        ST_IO_RD,
        ST_IO_CHK,
        ST_TICK_END
    } t_state;

    typedef struct packed {
        logic loaded_zero;
        logic scan_last;
        logic queues_empty;
        logic finish_hit;
        logic io_end;
    } t_stat;

endpackage

[rtl/tlfs_fifo.sv]
// ----------------------------------------------------------------------------
// tlfs_fifo
// Circular task index queue with a registered read of the head entry.
// ----------------------------------------------------------------------------
module tlfs_fifo #(
    parameter int DEPTH = 16,
    parameter int DW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_head_data,
    output logic          o_empty,
    output logic [CW-1:0] o_count
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_head;
    logic [DW-1:0] r_tail;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rd;

    function automatic logic [DW-1:0] wrap_inc(input logic [DW-1:0] p);
        logic [DW-1:0] q;
        if (p == DW'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_tail <= wrap_inc(r_tail);
            end
            if (i_pop) begin
                r_head <= wrap_inc(r_head);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rd <= r_mem[r_head];
    end

    assign o_head_data = r_rd;
    assign o_empty     = (r_cnt == '0);
    assign o_count     = r_cnt;

endmodule

[rtl/tlfs_ctrl.sv]
// ----------------------------------------------------------------------------
// tlfs_ctrl
// Sequencer: runs a load, or a tick's arrival scan, dispatch and I/O scan.
// ----------------------------------------------------------------------------
module tlfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mode,
    input  tlfs_pkg::t_stat i_stat,
    output tlfs_pkg::t_op  o_op,
    output logic           o_busy
);

    tlfs_pkg::t_state r_state;
    tlfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = tlfs_pkg::OP_NONE;
        case (r_state)
            tlfs_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_mode == tlfs_pkg::MODE_LOAD) begin
                        o_op = tlfs_pkg::OP_LOAD;
                    end else begin
                        o_op    = tlfs_pkg::OP_TICK_START;
                        n_state = i_stat.loaded_zero ? tlfs_pkg::ST_DSP_WAIT
                                                     : tlfs_pkg::ST_ARR_WAIT;
                    end
                end
            end
            tlfs_pkg::ST_ARR_WAIT: begin
                n_state = tlfs_pkg::ST_ARR_CHK;
            end
            tlfs_pkg::ST_ARR_CHK: begin
                o_op    = tlfs_pkg::OP_ARR_CHK;
                n_state = i_stat.scan_last ? tlfs_pkg::ST_DSP_WAIT
                                           : tlfs_pkg::ST_ARR_WAIT;
            end
            tlfs_pkg::ST_DSP_WAIT: begin
                n_state = i_stat.queues_empty ? tlfs_pkg::ST_IO_INIT
                                              : tlfs_pkg::ST_DSP_SEL;
            end
            tlfs_pkg::ST_DSP_SEL: begin
                o_op    = tlfs_pkg::OP_DSP_SEL;
                n_state = tlfs_pkg::ST_DSP_RD;
            end
            tlfs_pkg::ST_DSP_RD: begin
                n_state = tlfs_pkg::ST_DSP_EXE;
            end
            tlfs_pkg::ST_DSP_EXE: begin
                o_op    = tlfs_pkg::OP_DSP_EXE;
                n_state = i_stat.finish_hit ? tlfs_pkg::ST_DSP_DONE
                                            : tlfs_pkg::ST_IO_INIT;
            end
            tlfs_pkg::ST_DSP_DONE: begin
                o_op    = tlfs_pkg::OP_DSP_DONE;
                n_state = tlfs_pkg::ST_IO_INIT;
            end
            tlfs_pkg::ST_IO_INIT: begin
                o_op    = tlfs_pkg::OP_IO_INIT;
                n_state = tlfs_pkg::ST_IO_POP;
            end
            tlfs_pkg::ST_IO_POP: begin
                if (i_stat.io_end) begin
                    n_state = tlfs_pkg::ST_TICK_END;
                end else begin
                    o_op    = tlfs_pkg::OP_IO_POP;
                    n_state = tlfs_pkg::ST_IO_RD;
                end
            end
            tlfs_pkg::ST_IO_RD: begin
                n_state = tlfs_pkg::ST_IO_CHK;
            end
            tlfs_pkg::ST_IO_CHK: begin
                o_op    = tlfs_pkg::OP_IO_CHK;
                n_state = tlfs_pkg::ST_IO_POP;
            end
            tlfs_pkg::ST_TICK_END: begin
                o_op    = tlfs_pkg::OP_TICK_END;
                n_state = tlfs_pkg::ST_IDLE;
            end
            default: begin
                n_state = tlfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tlfs_pkg::ST_IDLE);

endmodule

[rtl/tlfs_dpath.sv]
// ----------------------------------------------------------------------------
// tlfs_dpath
// Task table, run queues, counters and result register.
// ----------------------------------------------------------------------------
module tlfs_dpath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlfs_pkg::t_op         i_op,
    output tlfs_pkg::t_stat       o_stat,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic [7:0]            i_task_ident,
    input  logic [15:0]           i_arrival_tick,
    input  logic [15:0]           i_service_ticks,
    input  logic signed [16:0]    i_disk_at,
    input  logic signed [16:0]    i_tape_at,
    input  logic signed [16:0]    i_printer_at,
    output logic                  o_res_valid,
    output logic [3:0]            o_event_res,
    output logic [7:0]            o_task_out,
    output logic [1:0]            o_io_type,
    output logic [15:0]           o_tick_now,
    output logic [15:0]           o_executed_out,
    output logic                  o_all_done,
    output logic                  o_last
);

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [7:0]       r_lat [tlfs_pkg::IO_KINDS];
    logic [15:0]      r_tick, n_tick;
    logic [CW-1:0]    r_loaded, n_loaded;
    logic [CW-1:0]    r_fin, n_fin;
    tlfs_pkg::t_rec   r_tab [MAX_TASKS];
    tlfs_pkg::t_rec   r_rec;
    logic [TW-1:0]    r_idx, n_idx;
    logic             r_arrived [MAX_TASKS];
    logic             r_from_high, n_from_high;
    logic [CW-1:0]    r_io_n, n_io_n;
    logic [CW-1:0]    r_io_j, n_io_j;

    logic             r_valid, n_valid;
    logic             r_last, n_last;
    logic [3:0]       r_ev, n_ev;
    logic [7:0]       r_task, n_task;
    logic [1:0]       r_kind, n_kind;
    logic [15:0]      r_exec, n_exec;

    logic             wr_en;
    logic [TW-1:0]    wr_addr;
    tlfs_pkg::t_rec   wr_data;
    logic             arr_set, arr_clr;

    logic             hq_push, hq_pop, lq_push, lq_pop, iq_push, iq_pop;
    logic [TW-1:0]    hq_din, lq_din, iq_din;
    logic [TW-1:0]    hq_head, lq_head, iq_head;
    logic             hq_empty, lq_empty, iq_empty;
    logic [CW-1:0]    hq_cnt, lq_cnt, iq_cnt;

    logic [tlfs_pkg::IO_KINDS-1:0] match;
    logic             io_found;
    tlfs_pkg::t_io_kind found_kind;
    logic [15:0]      exec_inc;
    logic             done_hit;
    logic [16:0]      ret_sum;
    logic [15:0]      ret_sat;

    tlfs_fifo #(.DEPTH(MAX_TASKS), .DW(TW), .CW(CW)) u_hq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(hq_push), .i_push_data(hq_din),
        .i_pop(hq_pop), .o_head_data(hq_head), .o_empty(hq_empty), .o_count(hq_cnt)
    );

    tlfs_fifo #(.DEPTH(MAX_TASKS), .DW(TW), .CW(CW)) u_lq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(lq_push), .i_push_data(lq_din),
        .i_pop(lq_pop), .o_head_data(lq_head), .o_empty(lq_empty), .o_count(lq_cnt)
    );

    tlfs_fifo #(.DEPTH(MAX_TASKS), .DW(TW), .CW(CW)) u_iq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(iq_push), .i_push_data(iq_din),
        .i_pop(iq_pop), .o_head_data(iq_head), .o_empty(iq_empty), .o_count(iq_cnt)
    );

    // I/O point match, first in the order disk, tape, printer
    always_comb begin
        for (int k = 0; k < tlfs_pkg::IO_KINDS; k++) begin
            match[k] = ({1'b0, r_rec.exec} == r_rec.pts[k]);
        end
        io_found = |match;
        if (match[0]) begin
            found_kind = tlfs_pkg::IO_DISK;
        end else if (match[1]) begin
            found_kind = tlfs_pkg::IO_TAPE;
        end else begin
            found_kind = tlfs_pkg::IO_PRINTER;
        end
        exec_inc = (r_rec.exec != tlfs_pkg::TICK_MAX) ? r_rec.exec + 16'd1 : r_rec.exec;
        done_hit = (exec_inc >= r_rec.svc);
        ret_sum  = {1'b0, r_tick} + {9'd0, r_lat[found_kind]};
        ret_sat  = ret_sum[16] ? tlfs_pkg::TICK_MAX : ret_sum[15:0];
    end

    always_comb begin
        n_tick      = r_tick;
        n_loaded    = r_loaded;
        n_fin       = r_fin;
        n_idx       = r_idx;
        n_from_high = r_from_high;
        n_io_n      = r_io_n;
        n_io_j      = r_io_j;
        n_valid     = 1'b0;
        n_last      = 1'b0;
        n_ev        = r_ev;
        n_task      = r_task;
        n_kind      = r_kind;
        n_exec      = r_exec;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_rec;
        arr_set     = 1'b0;
        arr_clr     = 1'b0;
        hq_push     = 1'b0;
        hq_pop      = 1'b0;
        lq_push     = 1'b0;
        lq_pop      = 1'b0;
        iq_push     = 1'b0;
        iq_pop      = 1'b0;
        hq_din      = r_idx;
        lq_din      = r_idx;
        iq_din      = r_idx;
        case (i_op)
            tlfs_pkg::OP_LOAD: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_task  = i_task_ident;
                n_kind  = '0;
                n_exec  = '0;
                if (r_loaded == CW'(MAX_TASKS)) begin
                    n_ev = tlfs_pkg::EV_REFUSED;
                end else begin
                    n_ev         = tlfs_pkg::EV_LOADED;
                    wr_en        = 1'b1;
                    wr_addr      = r_loaded[TW-1:0];
                    wr_data.id   = i_task_ident;
                    wr_data.arr  = i_arrival_tick;
                    wr_data.svc  = i_service_ticks;
                    wr_data.pts  = {i_printer_at, i_tape_at, i_disk_at};
                    wr_data.exec = '0;
                    wr_data.ret  = '0;
                    wr_data.kind = tlfs_pkg::IO_DISK;
                    arr_clr      = 1'b1;
                    n_loaded     = r_loaded + 1'b1;
                end
            end
            tlfs_pkg::OP_TICK_START: begin
                n_idx = '0;
            end
            tlfs_pkg::OP_ARR_CHK: begin
                if (!r_arrived[r_idx] && r_rec.arr == r_tick) begin
                    arr_set = 1'b1;
                    hq_push = 1'b1;
                    n_valid = 1'b1;
                    n_ev    = tlfs_pkg::EV_ARRIVED;
                    n_task  = r_rec.id;
                    n_kind  = '0;
                    n_exec  = r_rec.exec;
                end
                if (!o_stat.scan_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tlfs_pkg::OP_DSP_SEL: begin
                n_from_high = !hq_empty;
                if (!hq_empty) begin
                    hq_pop = 1'b1;
                    n_idx  = hq_head;
                end else begin
                    lq_pop = 1'b1;
                    n_idx  = lq_head;
                end
            end
            tlfs_pkg::OP_DSP_EXE: begin
                n_valid = 1'b1;
                n_task  = r_rec.id;
                wr_en   = 1'b1;
                if (io_found) begin
                    wr_data.ret             = ret_sat;
                    wr_data.kind            = found_kind;
                    wr_data.pts[found_kind] = '1;
                    iq_push = 1'b1;
                    n_ev    = r_from_high ? tlfs_pkg::EV_IO_HIGH : tlfs_pkg::EV_IO_LOW;
                    n_kind  = found_kind;
                    n_exec  = r_rec.exec;
                end else begin
                    wr_data.exec = exec_inc;
                    n_ev   = r_from_high ? tlfs_pkg::EV_RAN_HIGH : tlfs_pkg::EV_RAN_LOW;
                    n_kind = '0;
                    n_exec = exec_inc;
                    if (done_hit) begin
                        n_fin = r_fin + 1'b1;
                    end else if (r_from_high && hq_empty) begin
                        hq_push = 1'b1;
                    end else begin
                        lq_push = 1'b1;
                    end
                end
            end
            tlfs_pkg::OP_DSP_DONE: begin
                n_valid = 1'b1;
                n_ev    = tlfs_pkg::EV_DONE;
            end
            tlfs_pkg::OP_IO_INIT: begin
                n_io_n = iq_cnt;
                n_io_j = '0;
            end
            tlfs_pkg::OP_IO_POP: begin
                iq_pop = 1'b1;
                n_idx  = iq_head;
                n_io_j = r_io_j + 1'b1;
            end
            tlfs_pkg::OP_IO_CHK: begin
                if (r_rec.ret == r_tick) begin
                    if (r_rec.kind == tlfs_pkg::IO_DISK) begin
                        lq_push = 1'b1;
                    end else begin
                        hq_push = 1'b1;
                    end
                    n_valid = 1'b1;
                    n_ev    = tlfs_pkg::EV_IO_RET;
                    n_task  = r_rec.id;
                    n_kind  = r_rec.kind;
                    n_exec  = r_rec.exec;
                end else begin
                    iq_push = 1'b1;
                end
            end
            tlfs_pkg::OP_TICK_END: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_ev    = tlfs_pkg::EV_TICK_END;
                n_task  = '0;
                n_kind  = '0;
                n_exec  = '0;
                if (r_tick != tlfs_pkg::TICK_MAX) begin
                    n_tick = r_tick + 16'd1;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.loaded_zero  = (r_loaded == '0);
        o_stat.scan_last    = ((CW'(r_idx) + 1'b1) == r_loaded);
        o_stat.queues_empty = hq_empty && lq_empty;
        o_stat.finish_hit   = !io_found && done_hit;
        o_stat.io_end       = (r_io_j == r_io_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_loaded <= '0;
            r_fin    <= '0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
            for (int k = 0; k < tlfs_pkg::IO_KINDS; k++) begin
                r_lat[k] <= 8'd1;
            end
        end else begin
            r_tick   <= n_tick;
            r_loaded <= n_loaded;
            r_fin    <= n_fin;
            r_valid  <= n_valid;
            r_last   <= n_last;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    tlfs_pkg::REG_DISK_LAT:    r_lat[0] <= i_cfg_wdata;
                    tlfs_pkg::REG_TAPE_LAT:    r_lat[1] <= i_cfg_wdata;
                    tlfs_pkg::REG_PRINTER_LAT: r_lat[2] <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_from_high <= n_from_high;
        r_io_n      <= n_io_n;
        r_io_j      <= n_io_j;
        r_ev        <= n_ev;
        r_task      <= n_task;
        r_kind      <= n_kind;
        r_exec      <= n_exec;
        o_tick_now  <= r_tick;
        o_all_done  <= (n_fin == n_loaded);
        if (wr_en) begin
            r_tab[wr_addr] <= wr_data;
        end
        r_rec <= r_tab[r_idx];
        if (arr_clr) begin
            r_arrived[r_loaded[TW-1:0]] <= 1'b0;
        end else if (arr_set) begin
            r_arrived[r_idx] <= 1'b1;
        end
    end

    assign o_res_valid    = r_valid;
    assign o_last         = r_last;
    assign o_event_res    = r_ev;
    assign o_task_out     = r_task;
    assign o_io_type      = r_kind;
    assign o_executed_out = r_exec;

endmodule

[rtl/two_level_feedback_scheduler_core.sv]
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler_core
// Load item: one result word the cycle after start; the next start is taken then.
// Tick item: an arrival scan over the loaded tasks, at most one dispatch
// (with a done word when the task completes) and a scan of the I/O list; each
// scan reads the one-port task table once per entry.
// At most one word per cycle, the last carries o_last; words cannot be held off.
// Synchronous active-low reset clears counters, queues and latencies (to 1).
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [7:0]         i_task_ident,
    input  logic [15:0]        i_arrival_tick,
    input  logic [15:0]        i_service_ticks,
    input  logic signed [16:0] i_disk_at,
    input  logic signed [16:0] i_tape_at,
    input  logic signed [16:0] i_printer_at,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_addr,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_res_valid,
    output logic [3:0]         o_event_res,
    output logic [7:0]         o_task_out,
    output logic [1:0]         o_io_type,
    output logic [15:0]        o_tick_now,
    output logic [15:0]        o_executed_out,
    output logic               o_all_done,
    output logic               o_last
);

    tlfs_pkg::t_op   op;
    tlfs_pkg::t_stat stat;

    tlfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy)
    );

    tlfs_dpath #(.MAX_TASKS(MAX_TASKS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_stat          (stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_task_ident    (i_task_ident),
        .i_arrival_tick  (i_arrival_tick),
        .i_service_ticks (i_service_ticks),
        .i_disk_at       (i_disk_at),
        .i_tape_at       (i_tape_at),
        .i_printer_at    (i_printer_at),
        .o_res_valid     (o_res_valid),
        .o_event_res     (o_event_res),
        .o_task_out      (o_task_out),
        .o_io_type       (o_io_type),
        .o_tick_now      (o_tick_now),
        .o_executed_out  (o_executed_out),
        .o_all_done      (o_all_done),
        .o_last          (o_last)
    );

endmodule

[rtl/tlfs_checker.sv]
// ----------------------------------------------------------------------------
// tlfs_checker
// Port-level checks of the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module tlfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_mode,
    input logic       o_res_valid,
    input logic [3:0] o_event_res,
    input logic [7:0] o_task_out,
    input logic       o_last
);

    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_res_valid)
        else $error("last without valid word");

    a_load_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == tlfs_pkg::MODE_LOAD |=>
            o_res_valid && o_last &&
            (o_event_res == tlfs_pkg::EV_LOADED || o_event_res == tlfs_pkg::EV_REFUSED))
        else $error("load did not give a single load word");

    a_tick_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_event_res == tlfs_pkg::EV_TICK_END |-> o_last && o_task_out == 8'd0)
        else $error("tick end word malformed");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_res_valid && o_last && o_event_res == tlfs_pkg::EV_TICK_END)
        else $error("tick finished without tick end word");

    a_word_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy) || $past(start))
        else $error("word with no work in flight");

endmodule

bind two_level_feedback_scheduler_core tlfs_checker u_tlfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_mode      (i_mode),
    .o_res_valid (o_res_valid),
    .o_event_res (o_event_res),
    .o_task_out  (o_task_out),
    .o_last      (o_last)
);
